// ===== rtl/assert_macros.svh =====
// assertion helper macros for the deframer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define SFD_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("deframer check failed");

// antecedent implies consequent in the same cycle
`define SFD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");

`endif

// ===== rtl/sfd_pkg.sv =====
// shared types and constants for the serial frame deframer
// no dependencies; used by sfd_csr, serial_frame_deframer_core and the testbench
`timescale 1ns / 1ps

package sfd_pkg;

   // result kind codes
   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_GOOD     = 2'd1;
   localparam logic [1:0] KIND_BAD_SUM  = 2'd2;
   localparam logic [1:0] KIND_BAD_FOOT = 2'd3;

   // register map
   localparam int          ADDR_W        = 4;
   localparam logic [1:0]  REG_HEADER    = 2'd0;
   localparam logic [1:0]  REG_FOOTER    = 2'd1;
   localparam logic [1:0]  REG_MAX_LEN   = 2'd2;

   localparam logic [7:0]  HEADER_RESET  = 8'd170;
   localparam logic [7:0]  FOOTER_RESET  = 8'd85;
   localparam logic [7:0]  MAX_LEN_RESET = 8'd255;

   // parser phases
   typedef enum logic [6:0] {
      PH_HUNT   = 7'b0000001,
      PH_LEN    = 7'b0000010,
      PH_TYPE1  = 7'b0000100,
      PH_TYPE2  = 7'b0001000,
      PH_DATA   = 7'b0010000,
      PH_SUM    = 7'b0100000,
      PH_FOOTER = 7'b1000000
   } phase_type;

   // configuration seen by the parser
   typedef struct packed {
      logic [7:0] header_byte;
      logic [7:0] footer_byte;
      logic [7:0] max_length;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [7:0]  byte_index;
      logic [7:0]  frame_length;
      logic [15:0] frame_type;
   } rsp_type;

endpackage

// ===== rtl/sfd_csr.sv =====
// apb-style configuration registers of the deframer
// depends on sfd_pkg
`timescale 1ns / 1ps

module sfd_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [sfd_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output sfd_pkg::cfg_type           cfg
);

   sfd_pkg::cfg_type cfg_ff;
   sfd_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[3:2];

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            sfd_pkg::REG_HEADER:  cfg_in.header_byte = pwdata[7:0];
            sfd_pkg::REG_FOOTER:  cfg_in.footer_byte = pwdata[7:0];
            sfd_pkg::REG_MAX_LEN: cfg_in.max_length  = pwdata[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte <= sfd_pkg::HEADER_RESET;
         cfg_ff.footer_byte <= sfd_pkg::FOOTER_RESET;
         cfg_ff.max_length  <= sfd_pkg::MAX_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         sfd_pkg::REG_HEADER:  prdata = {24'd0, cfg_ff.header_byte};
         sfd_pkg::REG_FOOTER:  prdata = {24'd0, cfg_ff.footer_byte};
         sfd_pkg::REG_MAX_LEN: prdata = {24'd0, cfg_ff.max_length};
         default:              prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/serial_frame_deframer_core.sv =====
// serial frame deframer: byte-wide frame parser with cut-through payload
// results are registered before they drive rsp_*; throughput: one request
//   byte per cycle while the skid is empty; a two-entry output buffer (result register
//   plus skid register) keeps requests flowing while a result waits to be taken
// reset: synchronous, active high; parser returns to header hunt, registers take
//   their reset values, output buffer empties
`timescale 1ns / 1ps
`include "assert_macros.svh"

module serial_frame_deframer_core (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_rx_byte,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_kind,
   output logic [7:0]                 rsp_payload_byte,
   output logic [7:0]                 rsp_byte_index,
   output logic [7:0]                 rsp_frame_length,
   output logic [15:0]                rsp_frame_type,
   // configuration port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [sfd_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   sfd_pkg::cfg_type   cfg;

   sfd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         len_ff, len_in;
   logic [15:0]        type_ff, type_in;
   logic [7:0]         count_ff, count_in;

   sfd_pkg::rsp_type   res;
   logic               res_valid;

   sfd_pkg::rsp_type   main_ff, main_in;
   logic               main_v_ff, main_v_in;
   sfd_pkg::rsp_type   skid_ff, skid_in;
   logic               skid_v_ff, skid_v_in;

   logic               accept;
   logic               pop;
   logic [7:0]         c;
   logic [7:0]         count_inc;

   sfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_ready = !skid_v_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = main_v_ff && rsp_ready;
   assign c         = req_rx_byte;
   assign count_inc = count_ff + 8'd1;

   // frame parser next state and result
   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      len_in    = len_ff;
      type_in   = type_ff;
      count_in  = count_ff;
      res_valid = 1'b0;
      res.kind         = sfd_pkg::KIND_PAYLOAD;
      res.payload_byte = 8'd0;
      res.byte_index   = 8'd0;
      res.frame_length = len_ff;
      res.frame_type   = type_ff;
      if (accept) begin
         case (phase_ff)
            sfd_pkg::PH_HUNT: begin
               if (c == cfg.header_byte) begin
                  sum_in   = c;
                  phase_in = sfd_pkg::PH_LEN;
               end
            end
            sfd_pkg::PH_LEN: begin
               if (c > cfg.max_length) begin
                  phase_in = sfd_pkg::PH_HUNT;
               end else begin
                  sum_in   = sum_ff + c;
                  len_in   = c;
                  count_in = 8'd0;
                  phase_in = sfd_pkg::PH_TYPE1;
               end
            end
            sfd_pkg::PH_TYPE1: begin
               sum_in   = sum_ff + c;
               type_in  = {8'd0, c};
               phase_in = sfd_pkg::PH_TYPE2;
            end
            sfd_pkg::PH_TYPE2: begin
               sum_in   = sum_ff + c;
               type_in  = {type_ff[7:0], c};
               phase_in = (len_ff != 8'd0) ? sfd_pkg::PH_DATA : sfd_pkg::PH_SUM;
            end
            sfd_pkg::PH_DATA: begin
               sum_in           = sum_ff + c;
               res_valid        = 1'b1;
               res.payload_byte = c;
               res.byte_index   = count_ff;
               count_in         = count_inc;
               if (count_inc == len_ff) begin
                  phase_in = sfd_pkg::PH_SUM;
               end
            end
            sfd_pkg::PH_SUM: begin
               if (c == sum_ff) begin
                  phase_in = sfd_pkg::PH_FOOTER;
               end else begin
                  res_valid = 1'b1;
                  res.kind  = sfd_pkg::KIND_BAD_SUM;
                  phase_in  = sfd_pkg::PH_HUNT;
               end
            end
            sfd_pkg::PH_FOOTER: begin
               res_valid = 1'b1;
               res.kind  = (c == cfg.footer_byte) ? sfd_pkg::KIND_GOOD
                                                  : sfd_pkg::KIND_BAD_FOOT;
               phase_in  = sfd_pkg::PH_HUNT;
            end
            default: begin
               phase_in = sfd_pkg::PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfd_pkg::PH_HUNT;
         sum_ff   <= 8'd0;
         len_ff   <= 8'd0;
         type_ff  <= 16'd0;
         count_ff <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         len_ff   <= len_in;
         type_ff  <= type_in;
         count_ff <= count_in;
      end
   end

   // output buffer: result register with skid behind it
   always_comb begin
      main_in   = main_ff;
      main_v_in = main_v_ff;
      skid_in   = skid_ff;
      skid_v_in = skid_v_ff;
      if (pop) begin
         if (skid_v_ff) begin
            main_in   = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            main_v_in = 1'b0;
         end
      end
      if (res_valid) begin
         if (!main_v_ff || (pop && !skid_v_ff)) begin
            main_in   = res;
            main_v_in = 1'b1;
         end else begin
            skid_in   = res;
            skid_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = main_v_ff;
   assign rsp_kind         = main_ff.kind;
   assign rsp_payload_byte = main_ff.payload_byte;
   assign rsp_byte_index   = main_ff.byte_index;
   assign rsp_frame_length = main_ff.frame_length;
   assign rsp_frame_type   = main_ff.frame_type;

   // checks
   `SFD_ASSERT_IMPLIES(a_skid_behind_main, clock, reset, skid_v_ff, main_v_ff)
   `SFD_ASSERT_IMPLIES(a_payload_in_frame, clock, reset,
      rsp_valid && (rsp_kind == sfd_pkg::KIND_PAYLOAD), rsp_byte_index < rsp_frame_length)
   `SFD_ASSERT_IMPLIES(a_verdict_zeroed, clock, reset,
      rsp_valid && (rsp_kind != sfd_pkg::KIND_PAYLOAD),
      (rsp_payload_byte == 8'd0) && (rsp_byte_index == 8'd0))
   `SFD_ASSERT_IMPLIES(a_count_below_len, clock, reset,
      phase_ff == sfd_pkg::PH_DATA, count_ff < len_ff)

endmodule

// ===== test/frame_result_check.sv =====
// result prediction and comparison for the serial frame deframer testbench
// depends on sfd_pkg; watches the request, result and register ports of the core
`timescale 1ns / 1ps

module frame_result_check (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [7:0]                 req_rx_byte,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [1:0]                 rsp_kind,
   input  logic [7:0]                 rsp_payload_byte,
   input  logic [7:0]                 rsp_byte_index,
   input  logic [7:0]                 rsp_frame_length,
   input  logic [15:0]                rsp_frame_type,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [sfd_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   input  logic [31:0]                prdata,
   input  logic                       pready,
   input  logic                       end_of_run,
   output int                         outstanding,
   output int                         fail_count
);

   // shadow copy of the registers and the parser state
   sfd_pkg::cfg_type   cfg;
   sfd_pkg::phase_type parse_phase;
   logic [7:0]         frame_sum;
   logic [7:0]         frame_len;
   logic [7:0]         payload_seen;
   logic [15:0]        frame_word;

   // results still owed by the core, oldest first
   sfd_pkg::rsp_type   owed_results[$];
   int                 mismatches = 0;
   bit                 leftovers_done = 1'b0;

   assign fail_count = mismatches;

   // advance the parser by one request byte, queue the result it causes
   task automatic parse_byte(input logic [7:0] c);
      sfd_pkg::rsp_type r;
      bit               emit;
      r    = '0;
      emit = 1'b0;
      case (parse_phase)
         sfd_pkg::PH_HUNT: begin
            if (c == cfg.header_byte) begin
               frame_sum   = c;
               parse_phase = sfd_pkg::PH_LEN;
            end
         end
         sfd_pkg::PH_LEN: begin
            if (c > cfg.max_length) begin
               parse_phase = sfd_pkg::PH_HUNT;
            end else begin
               frame_sum    = frame_sum + c;
               frame_len    = c;
               payload_seen = 8'd0;
               parse_phase  = sfd_pkg::PH_TYPE1;
            end
         end
         sfd_pkg::PH_TYPE1: begin
            frame_sum   = frame_sum + c;
            frame_word  = {8'h00, c};
            parse_phase = sfd_pkg::PH_TYPE2;
         end
         sfd_pkg::PH_TYPE2: begin
            frame_sum  = frame_sum + c;
            frame_word = {frame_word[7:0], c};
            if (frame_len != 8'd0) parse_phase = sfd_pkg::PH_DATA;
            else parse_phase = sfd_pkg::PH_SUM;
         end
         sfd_pkg::PH_DATA: begin
            frame_sum      = frame_sum + c;
            r.kind         = sfd_pkg::KIND_PAYLOAD;
            r.payload_byte = c;
            r.byte_index   = payload_seen;
            emit           = 1'b1;
            payload_seen   = payload_seen + 8'd1;
            if (payload_seen == frame_len) parse_phase = sfd_pkg::PH_SUM;
         end
         sfd_pkg::PH_SUM: begin
            if (c == frame_sum) begin
               parse_phase = sfd_pkg::PH_FOOTER;
            end else begin
               r.kind      = sfd_pkg::KIND_BAD_SUM;
               emit        = 1'b1;
               parse_phase = sfd_pkg::PH_HUNT;
            end
         end
         sfd_pkg::PH_FOOTER: begin
            r.kind      = (c == cfg.footer_byte) ? sfd_pkg::KIND_GOOD : sfd_pkg::KIND_BAD_FOOT;
            emit        = 1'b1;
            parse_phase = sfd_pkg::PH_HUNT;
         end
         default: parse_phase = sfd_pkg::PH_HUNT;
      endcase
      if (emit) begin
         r.frame_length = frame_len;
         r.frame_type   = frame_word;
         owed_results.push_back(r);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      sfd_pkg::rsp_type want;
      logic [7:0]       reg_now;
      if (reset) begin
         cfg.header_byte = sfd_pkg::HEADER_RESET;
         cfg.footer_byte = sfd_pkg::FOOTER_RESET;
         cfg.max_length  = sfd_pkg::MAX_LEN_RESET;
         parse_phase     = sfd_pkg::PH_HUNT;
         frame_sum       = 8'd0;
         frame_len       = 8'd0;
         payload_seen    = 8'd0;
         frame_word      = 16'd0;
         owed_results.delete();
      end else begin
         // register writes update the shadow, reads are checked against it
         if (psel && penable && pready) begin
            case (paddr[sfd_pkg::ADDR_W-1:2])
               sfd_pkg::REG_HEADER:  reg_now = cfg.header_byte;
               sfd_pkg::REG_FOOTER:  reg_now = cfg.footer_byte;
               sfd_pkg::REG_MAX_LEN: reg_now = cfg.max_length;
               default:              reg_now = 8'h00;
            endcase
            if (pwrite) begin
               case (paddr[sfd_pkg::ADDR_W-1:2])
                  sfd_pkg::REG_HEADER:  cfg.header_byte = pwdata[7:0];
                  sfd_pkg::REG_FOOTER:  cfg.footer_byte = pwdata[7:0];
                  sfd_pkg::REG_MAX_LEN: cfg.max_length  = pwdata[7:0];
                  default: ;
               endcase
            end else begin
               compare_field("register read", {24'h0, reg_now}, prdata);
            end
         end

         // accepted request byte
         if (req_valid && req_ready) parse_byte(req_rx_byte);

         // accepted result against the oldest owed one
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0d byte %0d",
                        $time, rsp_kind, rsp_payload_byte);
               mismatches++;
            end else begin
               want = owed_results.pop_front();
               compare_field("kind", 32'(want.kind), 32'(rsp_kind));
               compare_field("payload_byte", 32'(want.payload_byte), 32'(rsp_payload_byte));
               compare_field("byte_index", 32'(want.byte_index), 32'(rsp_byte_index));
               compare_field("frame_length", 32'(want.frame_length), 32'(rsp_frame_length));
               compare_field("frame_type", 32'(want.frame_type), 32'(rsp_frame_type));
            end
         end

         // results never delivered
         if (end_of_run && !leftovers_done) begin
            leftovers_done = 1'b1;
            if (owed_results.size() != 0) begin
               $display("%0t: missing results, expected 0 left, actual %0d left",
                        $time, owed_results.size());
               mismatches += owed_results.size();
            end
         end
      end
      outstanding <= owed_results.size();
   end

endmodule

// ===== test/tb_top.sv =====
// top of the serial frame deframer testbench: clock, reset, byte and register stimulus
// depends on sfd_pkg, serial_frame_deframer_core and frame_result_check
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 300;

   // kinds of frame the byte generator can build
   localparam int MODE_GOOD     = 0;
   localparam int MODE_BAD_SUM  = 1;
   localparam int MODE_BAD_FOOT = 2;
   localparam int MODE_OVERSIZE = 3;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic [7:0]                 req_rx_byte = 8'h00;
   logic                       rsp_ready   = 1'b0;
   logic                       psel        = 1'b0;
   logic                       penable     = 1'b0;
   logic                       pwrite      = 1'b0;
   logic [sfd_pkg::ADDR_W-1:0] paddr       = '0;
   logic [31:0]                pwdata      = 32'h0;
   logic                       end_of_run  = 1'b0;

   logic                       req_ready;
   logic                       rsp_valid;
   logic [1:0]                 rsp_kind;
   logic [7:0]                 rsp_payload_byte;
   logic [7:0]                 rsp_byte_index;
   logic [7:0]                 rsp_frame_length;
   logic [15:0]                rsp_frame_type;
   logic [31:0]                prdata;
   logic                       pready;
   int                         outstanding;
   int                         fail_count;

   // register values the generator builds frames for
   logic [7:0] cur_header = sfd_pkg::HEADER_RESET;
   logic [7:0] cur_footer = sfd_pkg::FOOTER_RESET;
   logic [7:0] cur_max    = sfd_pkg::MAX_LEN_RESET;

   int  send_idle_pct = 0;
   int  stall_pct     = 0;
   bit  hold_go       = 1'b0;
   bit  hold_taken    = 1'b0;
   int  hold_left     = 0;
   int  cycle_count   = 0;

   int  bytes_sent      = 0;
   int  noise_bytes     = 0;
   int  good_frames     = 0;
   int  bad_sum_frames  = 0;
   int  bad_foot_frames = 0;
   int  oversize_frames = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   serial_frame_deframer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .rsp_frame_type   (rsp_frame_type),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   frame_result_check result_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .rsp_frame_type   (rsp_frame_type),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .end_of_run       (end_of_run),
      .outstanding      (outstanding),
      .fail_count       (fail_count)
   );

   // result side: random stalls, plus one long hold-off when asked
   always @(posedge clock) begin
      if (hold_go && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run timed out after %0d cycles", CYCLE_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   // offer one request byte, with optional idle cycles first, until taken
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_noise(input int n);
      int k;
      for (k = 0; k < n; k++) send_byte(8'($urandom));
      noise_bytes += n;
   endtask

   // header, length, type, payload, checksum and footer, corrupted per mode; oversize stops after length
   task automatic send_frame(input int mode, input int len, input logic [15:0] ftype);
      logic [7:0] csum;
      logic [7:0] b;
      int         k;
      send_byte(cur_header);
      csum = cur_header;
      send_byte(8'(len));
      if (mode == MODE_OVERSIZE) begin
         oversize_frames++;
      end else begin
         csum = csum + 8'(len);
         send_byte(ftype[15:8]);
         csum = csum + ftype[15:8];
         send_byte(ftype[7:0]);
         csum = csum + ftype[7:0];
         for (k = 0; k < len; k++) begin
            b = 8'($urandom);
            send_byte(b);
            csum = csum + b;
         end
         case (mode)
            MODE_BAD_SUM: begin
               // footer still follows, parser should be hunting by then
               send_byte(csum + 8'($urandom_range(255, 1)));
               send_byte(cur_footer);
               bad_sum_frames++;
            end
            MODE_BAD_FOOT: begin
               send_byte(csum);
               send_byte(cur_footer ^ 8'($urandom_range(255, 1)));
               bad_foot_frames++;
            end
            default: begin
               send_byte(csum);
               send_byte(cur_footer);
               good_frames++;
            end
         endcase
      end
   endtask

   // mostly well-formed frames of small length, some broken ones and stray bytes
   task automatic random_traffic(input int quota);
      int start;
      int pick;
      int cap;
      start = bytes_sent - noise_bytes;
      while (bytes_sent - noise_bytes - start < quota) begin
         pick = $urandom_range(99);
         cap  = (cur_max < 12) ? cur_max : 12;
         if ($urandom_range(7) == 0) cap = (cur_max < 40) ? cur_max : 40;
         if (pick < 64)
            send_frame(MODE_GOOD, $urandom_range(cap), 16'($urandom));
         else if (pick < 76)
            send_frame(MODE_BAD_SUM, $urandom_range(cap), 16'($urandom));
         else if (pick < 88)
            send_frame(MODE_BAD_FOOT, $urandom_range(cap), 16'($urandom));
         else if (pick < 95 && cur_max < 255)
            send_frame(MODE_OVERSIZE, $urandom_range(255, cur_max + 1), 16'h0000);
         else
            send_noise($urandom_range(4, 1));
      end
   endtask

   // one register access: setup cycle, then access cycle until pready
   task automatic reg_access(input logic [1:0] idx, input bit is_write, input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] h, input logic [7:0] f, input logic [7:0] m);
      reg_access(sfd_pkg::REG_HEADER, 1'b1, h);
      reg_access(sfd_pkg::REG_FOOTER, 1'b1, f);
      reg_access(sfd_pkg::REG_MAX_LEN, 1'b1, m);
      reg_access(sfd_pkg::REG_HEADER, 1'b0, 8'h00);
      reg_access(sfd_pkg::REG_FOOTER, 1'b0, 8'h00);
      reg_access(sfd_pkg::REG_MAX_LEN, 1'b0, 8'h00);
      cur_header = h;
      cur_footer = f;
      cur_max    = m;
   endtask

   // stop offering, wait for every owed result, then let the pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: byte extremes while hunting, empty frame, type extremes, bad endings
      send_byte(8'h00);
      send_byte(8'hFF);
      noise_bytes += 2;
      send_frame(MODE_GOOD, 0, 16'h0000);
      send_frame(MODE_BAD_FOOT, 2, 16'hFFFF);
      send_frame(MODE_BAD_SUM, 1, 16'h1234);

      // long result hold-off while a long frame keeps coming
      hold_go = 1'b1;
      send_frame(MODE_GOOD, 40, 16'($urandom));
      random_traffic(120);
      settle();

      // zero length limit, extreme header and footer, sender gaps
      set_config(8'h00, 8'hFF, 8'd0);
      send_idle_pct = 63;
      random_traffic(120);
      settle();

      // opposite extremes, mid limit, receiver stalls
      set_config(8'hFF, 8'h00, 8'd20);
      send_idle_pct = 0;
      stall_pct     = 63;
      random_traffic(120);
      settle();

      // random header and footer, full limit, gaps on both sides
      set_config(8'($urandom), 8'($urandom), 8'd255);
      send_idle_pct = 28;
      stall_pct     = 28;
      send_frame(MODE_GOOD, 255, 16'($urandom));
      random_traffic(120);
      settle();

      end_of_run <= 1'b1;
      repeat (2) @(posedge clock);

      $display("covered %0d frames: %0d good, %0d bad checksum, %0d bad footer, %0d too long",
               good_frames + bad_sum_frames + bad_foot_frames + oversize_frames,
               good_frames, bad_sum_frames, bad_foot_frames, oversize_frames);
      $display("%0d request bytes (%0d stray) over four register settings and idle mixes",
               bytes_sent, noise_bytes);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sfd_csr.sv
rtl/serial_frame_deframer_core.sv
test/frame_result_check.sv
test/tb_top.sv
